FILE: rtl/tlspq_pkg.sv
package tlspq_pkg;

    // Default queue depth
    localparam int DEFAULT_DEPTH = 16;

    // Field widths
    localparam int TAG_W  = 16;
    localparam int PRIO_W = 2;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

    // Priority levels
    localparam logic [PRIO_W-1:0] PRIO_NONE  = 2'd0;
    localparam logic [PRIO_W-1:0] PRIO_GREEN = 2'd1;

    typedef struct packed {
        logic              op;
        logic [PRIO_W-1:0] priority_req;
        logic [TAG_W-1:0]  tag;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [TAG_W-1:0]  out_tag;
        logic [PRIO_W-1:0] out_priority;
        logic [OCC_W-1:0]  occupancy;
    } out_item_t;

    // One stored entry
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic   ins;
        logic   rem;
        entry_t entry;
    } cell_cmd_t;

endpackage

FILE: rtl/tlspq_cell.sv
module tlspq_cell (
    input  logic               aclk,
    input  tlspq_pkg::cell_cmd_t cmd,
    input  logic               occ,
    input  logic               left_ge,
    input  tlspq_pkg::entry_t  left_entry,
    input  tlspq_pkg::entry_t  right_entry,
    output tlspq_pkg::entry_t  entry_q,
    output logic               ge
);
    import tlspq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // stored entry ranks at or above the incoming priority
    assign ge      = occ && (entry_reg.prio >= cmd.entry.prio);
    assign entry_q = entry_reg;

    // insert: keep, take the new entry, or shift right; remove: shift left
    always_comb begin
        entry_next = entry_reg;
        if (cmd.ins) begin
            if (!ge) begin
                entry_next = left_ge ? cmd.entry : left_entry;
            end
        end else if (cmd.rem) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

FILE: rtl/three_level_stable_priority_queue_unit.sv
// Channel  Direction  Payload     Handshake
// s_       in         in_item_t   s_valid / s_ready
// m_       out        out_item_t  m_valid / m_ready
//
// Each item is applied to the cell row in the cycle it is accepted; its result
// sits in the output register in the next cycle. One item per cycle with m_ready high:
// every cell decides keep / take / shift from its own and left neighbor's compare.
// Reset (aresetn low, synchronous) empties the queue and drops any pending result.
// A stalled result holds the input off only until m_ready returns.
module three_level_stable_priority_queue_unit #(
    parameter int QUEUE_DEPTH = tlspq_pkg::DEFAULT_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  tlspq_pkg::in_item_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output tlspq_pkg::out_item_t m_data
);
    import tlspq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    out_item_t        m_data_reg;
    out_item_t        m_data_next;

    logic      accept;
    logic      full;
    logic      empty;
    cell_cmd_t cmd;

    entry_t    cell_entry [QUEUE_DEPTH];
    logic      cell_ge    [QUEUE_DEPTH];

    logic [CNT_W+OCC_W-1:0] occ_wide;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);

    // command to the row; priority zero is stored as green
    always_comb begin
        cmd.ins        = accept && (s_data.op == OP_INSERT) && !full;
        cmd.rem        = accept && (s_data.op == OP_REMOVE) && !empty;
        cmd.entry.tag  = s_data.tag;
        cmd.entry.prio = (s_data.priority_req == PRIO_NONE) ? PRIO_GREEN
                                                            : s_data.priority_req;
    end

    // cell row, slot 0 is the head
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic   occ_i;
        logic   left_ge_i;
        entry_t left_i;
        entry_t right_i;

        assign occ_i = (cnt_reg > CNT_W'(i));

        if (i == 0) begin : g_head
            assign left_ge_i = 1'b1;
            assign left_i    = cmd.entry;
        end else begin : g_mid
            assign left_ge_i = cell_ge[i-1];
            assign left_i    = cell_entry[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign right_i = cell_entry[i];
        end else begin : g_body
            assign right_i = cell_entry[i+1];
        end

        tlspq_cell u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .occ         (occ_i),
            .left_ge     (left_ge_i),
            .left_entry  (left_i),
            .right_entry (right_i),
            .entry_q     (cell_entry[i]),
            .ge          (cell_ge[i])
        );
    end

    // count update
    always_comb begin
        cnt_next = cnt_reg;
        if (cmd.ins) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (cmd.rem) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    assign occ_wide = {{OCC_W{1'b0}}, cnt_next};

    // result item
    always_comb begin
        m_data_next              = m_data_reg;
        m_valid_next             = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next             = 1'b1;
            m_data_next.status       = STATUS_OK;
            m_data_next.out_tag      = '0;
            m_data_next.out_priority = PRIO_NONE;
            m_data_next.occupancy    = occ_wide[OCC_W-1:0];
            if (s_data.op == OP_INSERT) begin
                if (full) begin
                    m_data_next.status = STATUS_FULL;
                end
            end else if (empty) begin
                m_data_next.status = STATUS_EMPTY;
            end else begin
                m_data_next.out_tag      = cell_entry[0].tag;
                m_data_next.out_priority = cell_entry[0].prio;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
